@@ rtl/sopm_pkg.sv @@
// Shared types, constants and the arctangent table of the plant model step.
package sopm_pkg;

  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 16;
  localparam int MQW       = 31;
  localparam int DNW       = 64;
  localparam int DDW       = 36;
  localparam int ZW        = 36;
  localparam int CW        = 34;
  localparam int STEP_W    = 5;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam longint               TWO_PI_Q32  = 64'sd26986075409;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [DDW-1:0]       K27_Q28     = 36'd7247757312;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic   go;
    md_op_t op;
  } md_ctl_t;

  typedef enum logic [2:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_MODE,
    REG_INIT_Y_OLDER,
    REG_INIT_Y_LAST,
    REG_INIT_U_LAST
  } cfg_reg_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0: a = 36'sd843314857;
      5'd1: a = 36'sd497837829;
      5'd2: a = 36'sd263043837;
      5'd3: a = 36'sd133525159;
      5'd4: a = 36'sd67021687;
      5'd5: a = 36'sd33543516;
      5'd6: a = 36'sd16775851;
      5'd7: a = 36'sd8388437;
      5'd8: a = 36'sd4194283;
      5'd9: a = 36'sd2097149;
      default: a = ZW'(1) << (STEP_W'(30) - i);
    endcase
    return a;
  endfunction

endpackage

@@ rtl/sopm_muldiv.sv @@
// Bit-serial shift-add multiplier and restoring divider shared by all products.
module sopm_muldiv import sopm_pkg::*; #(
  parameter int MW = 36
) (
  input  logic                     clk,
  input  logic                     rst,
  input  md_ctl_t                  ctl,
  input  logic signed [MQW-1:0]    mul_q,
  input  logic signed [MW-1:0]     mul_m,
  input  logic [DNW-1:0]           div_n,
  input  logic [DDW-1:0]           div_d,
  output logic                     done,
  output logic signed [MW+MQW-1:0] prod,
  output logic [DNW-1:0]           quo
);

  localparam int PW    = MW + MQW;
  localparam int CNT_W = $clog2(DNW);

  logic                  busy;
  md_op_t                op;
  logic [CNT_W-1:0]      cnt;
  logic signed [PW-1:0]  mm;
  logic [MQW-1:0]        mq;
  logic [DDW-1:0]        dd;
  logic [DDW-1:0]        rem;
  logic                  last;
  logic signed [PW-1:0]  term;
  logic signed [PW-1:0]  prod_next;
  logic [DDW:0]          trial;
  logic [DDW:0]          diff;
  logic                  q_bit;

  always_comb begin
    last      = (op == MD_MUL) ? (cnt == CNT_W'(MQW - 1)) : (cnt == CNT_W'(DNW - 1));
    term      = mq[0] ? mm : '0;
    prod_next = (cnt == CNT_W'(MQW - 1)) ? prod - term : prod + term;
    trial     = {rem, quo[DNW-1]};
    diff      = trial - {1'b0, dd};
    q_bit     = !diff[DDW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= '0;
        prod <= '0;
        mm   <= PW'(mul_m);
        mq   <= mul_q;
        quo  <= div_n;
        dd   <= div_d;
        rem  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        case (op)
          MD_MUL: begin
            prod <= prod_next;
            mm   <= mm <<< 1;
            mq   <= mq >> 1;
          end
          MD_DIV: begin
            rem <= q_bit ? diff[DDW-1:0] : trial[DDW-1:0];
            quo <= {quo[DNW-2:0], q_bit};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/sopm_cordic.sv @@
// Iterative rotation-mode CORDIC producing the sine of a folded angle in Q.30.
module sopm_cordic import sopm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] sin_q30
);

  logic                 busy;
  logic [STEP_W-1:0]    i;
  logic signed [CW-1:0] x;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ang;

  always_comb begin
    dx  = sin_q30 >>> i;
    dy  = x >>> i;
    ang = atan_q30(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy    <= 1'b1;
        i       <= '0;
        x       <= CORDIC_GAIN;
        sin_q30 <= '0;
        z       <= z0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (!z[ZW-1]) begin
          x       <= x - dx;
          sin_q30 <= sin_q30 + dy;
          z       <= z - ang;
        end else begin
          x       <= x + dx;
          sin_q30 <= sin_q30 - dy;
          z       <= z + ang;
        end
        if (i == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/second_order_plant_model_step.sv @@
// Top level of the second-order plant model: sequencer, history and limiter.
// Each control word produces one plant output word. All products go through one
// bit-serial multiply/divide unit and the sine through a 30-step CORDIC. The sine
// angle is reduced by a reciprocal multiply, a back-multiply and subtraction of the
// period until the remainder is below it. A nonlinear step runs seven multiplies,
// plus two multiplies and one divide for the tanh when |y2| is below 3, and one
// CORDIC run. Input is taken only between steps; a finished output word may wait
// in the output register while the next input word is taken.
module second_order_plant_model_step import sopm_pkg::*; #(
  parameter int SAMPLE_FRAC_BITS = 16,
  parameter int SAMPLE_WIDTH     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] control_in,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] plant_out,
  output logic                           was_limited
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = SAMPLE_FRAC_BITS;
  localparam int MW = (W + 1 > 36) ? W + 1 : 36;
  localparam int PW = MW + MQW;
  localparam int SW = W + 10;
  localparam longint P_L     = (TWO_PI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
  localparam longint LIM_L   = 64'sd1000 <<< F;
  localparam longint SMAX_L  = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam longint SMIN_L  = -SMAX_L - 64'sd1;
  localparam longint HI_L    = (LIM_L < SMAX_L) ? LIM_L : SMAX_L;
  localparam longint LO_L    = (-LIM_L > SMIN_L) ? -LIM_L : SMIN_L;
  localparam logic [DDW-1:0] P_D = DDW'(P_L);
  localparam logic [63:0] P_U = 64'(P_L);
  localparam logic signed [MQW-1:0] P_Q   = MQW'(P_L);
  localparam logic signed [MQW-1:0] RCP_Q = MQW'((64'sd1 <<< (32 + F)) / P_L);
  localparam logic [63:0] THREE_F = 64'd3 << F;
  localparam logic signed [SW-1:0] SMAX_S = SW'(SMAX_L);
  localparam logic signed [SW-1:0] SMIN_S = SW'(SMIN_L);
  localparam logic signed [SW-1:0] HI_NL  = SW'(HI_L);
  localparam logic signed [SW-1:0] LO_NL  = SW'(LO_L);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_X2, S_NUM, S_DIV, S_SQ, S_MB, S_QEST,
    S_MOD, S_FIX, S_SIN, S_MD, S_MA, S_MU, S_FINISH
  } state_t;

  state_t state;

  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic                     model_mode;
  logic signed [W-1:0]      init_y_older, init_y_last, init_u_last;
  logic signed [W-1:0]      y_last, y_older, u_last, u_cur;
  logic signed [SW-1:0]     sum;
  logic [W-1:0]             mag_r;
  logic [W-1:0]             mod_r;
  logic [29:0]              xv;
  logic [31:0]              sv;

  md_ctl_t                  md_ctl;
  logic signed [MQW-1:0]    md_q;
  logic signed [MW-1:0]     md_m;
  logic [DNW-1:0]           md_n;
  logic [DDW-1:0]           md_d;
  logic                     md_done;
  logic signed [PW-1:0]     md_prod;
  logic [DNW-1:0]           md_quo;

  logic                     cd_go;
  logic signed [ZW-1:0]     cd_z;
  logic                     cd_done;
  logic signed [CW-1:0]     cd_sin;

  logic [W-1:0]             mag_y;
  logic [W-1:0]             mag_u;
  logic                     mag_big;
  logic [63:0]              x_w;
  logic signed [PW-1:0]     prod_sh;
  logic signed [PW-1:0]     q_est;
  logic signed [SW-1:0]     term;
  logic [DDW-1:0]           r_adj;
  logic signed [ZW-1:0]     z_raw;
  logic signed [ZW-1:0]     z_wrap;
  logic signed [ZW-1:0]     z_fold;
  logic signed [CW-1:0]     sin_s;
  logic [DDW-1:0]           den;
  logic signed [SW-1:0]     hi, lo;
  logic signed [SW-1:0]     y_lim;
  logic                     lim;

  sopm_muldiv #(.MW(MW)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .ctl   (md_ctl),
    .mul_q (md_q),
    .mul_m (md_m),
    .div_n (md_n),
    .div_d (md_d),
    .done  (md_done),
    .prod  (md_prod),
    .quo   (md_quo)
  );

  sopm_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .go      (cd_go),
    .z0      (cd_z),
    .done    (cd_done),
    .sin_q30 (cd_sin)
  );

  always_comb begin
    in_ready = (state == S_IDLE);
    mag_y    = y_older[W-1] ? W'(-y_older) : W'(y_older);
    mag_u    = u_last[W-1] ? W'(-u_last) : W'(u_last);
    mag_big  = 64'(mag_y) >= THREE_F;
    x_w      = 64'(mag_y) << (28 - F);
    prod_sh  = md_prod >>> COEF_FRAC;
    q_est    = md_prod >>> (32 + F);
    term     = prod_sh[SW-1:0];
    den      = K27_Q28 + DDW'(sv) + DDW'({sv, 3'b000});
    r_adj    = (u_last[W-1] && mod_r != '0) ? P_D - DDW'(mod_r) : DDW'(mod_r);
    z_raw    = $signed(ZW'(r_adj) << (30 - F));
    z_wrap   = (z_raw > PI_Q30) ? z_raw - TWO_PI_Q30 : z_raw;
    if (z_wrap > HALF_PI_Q30) begin
      z_fold = PI_Q30 - z_wrap;
    end else if (z_wrap < -HALF_PI_Q30) begin
      z_fold = -PI_Q30 - z_wrap;
    end else begin
      z_fold = z_wrap;
    end
    sin_s = cd_sin >>> (30 - F);
    hi    = model_mode ? HI_NL : SMAX_S;
    lo    = model_mode ? LO_NL : SMIN_S;
    lim   = (sum > hi) || (sum < lo);
    y_lim = (sum > hi) ? hi : ((sum < lo) ? lo : sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      coef_d       <= '0;
      model_mode   <= 1'b0;
      init_y_older <= '0;
      init_y_last  <= '0;
      init_u_last  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_A:       coef_a       <= cfg_data[COEF_W-1:0];
        REG_COEF_B:       coef_b       <= cfg_data[COEF_W-1:0];
        REG_COEF_C:       coef_c       <= cfg_data[COEF_W-1:0];
        REG_COEF_D:       coef_d       <= cfg_data[COEF_W-1:0];
        REG_MODE:         model_mode   <= cfg_data[0];
        REG_INIT_Y_OLDER: init_y_older <= cfg_data;
        REG_INIT_Y_LAST:  init_y_last  <= cfg_data;
        REG_INIT_U_LAST:  init_u_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      md_ctl    <= '0;
      cd_go     <= 1'b0;
      out_valid <= 1'b0;
      y_last    <= '0;
      y_older   <= '0;
      u_last    <= '0;
    end else begin
      md_ctl.go <= 1'b0;
      cd_go     <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            u_cur <= control_in;
            sum   <= '0;
            if (restart) begin
              y_last  <= init_y_last;
              y_older <= init_y_older;
              u_last  <= init_u_last;
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          md_ctl.go <= 1'b1;
          md_ctl.op <= MD_MUL;
          mag_r     <= mag_y;
          if (!model_mode) begin
            md_q  <= MQW'(coef_a);
            md_m  <= MW'(y_last);
            state <= S_MA;
          end else if (mag_big) begin
            md_q  <= MQW'(18'd65536);
            md_m  <= MW'(mag_y);
            state <= S_SQ;
          end else begin
            xv    <= x_w[29:0];
            md_q  <= MQW'(x_w[29:0]);
            md_m  <= MW'(x_w[29:0]);
            state <= S_X2;
          end
        end
        S_X2: begin
          if (md_done) begin
            sv        <= md_prod[59:28];
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= MQW'(xv);
            md_m      <= MW'(K27_Q28 + DDW'(md_prod[59:28]));
            state     <= S_NUM;
          end
        end
        S_NUM: begin
          if (md_done) begin
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_DIV;
            md_n      <= md_prod[DNW-1:0];
            md_d      <= den;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (md_done) begin
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= MQW'(md_quo[28:12]);
            md_m      <= MW'(mag_r);
            state     <= S_SQ;
          end
        end
        S_SQ: begin
          if (md_done) begin
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= MQW'(coef_b);
            md_m      <= MW'(md_prod[W+15:16]);
            state     <= S_MB;
          end
        end
        S_MB: begin
          if (md_done) begin
            sum       <= sum - term;
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= RCP_Q;
            md_m      <= MW'(mag_u);
            state     <= S_QEST;
          end
        end
        S_QEST: begin
          if (md_done) begin
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= P_Q;
            md_m      <= q_est[MW-1:0];
            state     <= S_MOD;
          end
        end
        S_MOD: begin
          if (md_done) begin
            mod_r <= mag_u - md_prod[W-1:0];
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (64'(mod_r) >= P_U) begin
            mod_r <= mod_r - P_U[W-1:0];
          end else begin
            cd_go <= 1'b1;
            cd_z  <= z_fold;
            state <= S_SIN;
          end
        end
        S_SIN: begin
          if (cd_done) begin
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= MQW'(coef_d);
            md_m      <= MW'(sin_s);
            state     <= S_MD;
          end
        end
        S_MD: begin
          if (md_done) begin
            sum       <= sum + term;
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= MQW'(coef_a);
            md_m      <= MW'(y_last);
            state     <= S_MA;
          end
        end
        S_MA: begin
          if (md_done) begin
            sum       <= sum + term;
            md_ctl.go <= 1'b1;
            md_ctl.op <= MD_MUL;
            md_q      <= model_mode ? MQW'(coef_c) : MQW'(coef_b);
            md_m      <= MW'(u_cur);
            state     <= S_MU;
          end
        end
        S_MU: begin
          if (md_done) begin
            sum   <= sum + term;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            plant_out   <= y_lim[W-1:0];
            was_limited <= lim;
            out_valid   <= 1'b1;
            u_last      <= u_cur;
            y_older     <= y_last;
            y_last      <= y_lim[W-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a step is in progress");

  a_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !md_done && !cd_done)
    else $error("arithmetic unit finished with no step in progress");

  a_limit_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_limited |->
      plant_out == HI_NL[W-1:0] || plant_out == LO_NL[W-1:0] ||
      plant_out == SMAX_S[W-1:0] || plant_out == SMIN_S[W-1:0])
    else $error("limited output is not at a limit");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the second-order plant model step block.
module tb_top import sopm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 32;
  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam longint CLAMP_Q16 = longint'(1000) <<< 16;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint ATAN_TAB [10] = '{843314857, 497837829, 263043837, 133525159,
                                       67021687, 33543516, 16775851, 8388437,
                                       4194283, 2097149};

  typedef struct {
    logic [SW-1:0] u;
    logic          rs;
  } ctl_word_t;

  typedef struct {
    logic [SW-1:0] y;
    logic          lim;
  } plant_word_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [SW-1:0] cfg_data;
  logic in_valid, in_ready, restart, out_valid, out_ready, was_limited;
  logic signed [SW-1:0] control_in, plant_out;

  ctl_word_t   ctl_queue [$];
  plant_word_t plant_expected [$];

  longint k_a, k_b, k_c, k_d, iy_older, iy_last, iu_last;
  longint y_hist1, y_hist2, u_hist;
  logic   nonlinear;
  bit     no_idle;
  bit     hold_req;
  int     hold_left;
  int     errors, n_lin, n_nl, n_lim, n_restart;
  longint cycles;

  second_order_plant_model_step i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .control_in(control_in), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready), .plant_out(plant_out),
    .was_limited(was_limited)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint coef_mul(longint k, longint x);
    longint hi, lo;
    hi = k >>> 16;
    lo = k - hi * 65536;
    return x * hi + ((x * lo) >>> 16);
  endfunction

  function automatic longint damp_term(longint v);
    longint a, t, x, s;
    longint unsigned p;
    a = v < 0 ? -v : v;
    if (a >= (longint'(3) <<< 16)) begin
      t = longint'(1) <<< 28;
    end else begin
      x = a <<< 12;
      p = longint'(x) * longint'(x);
      s = longint'(p >> 28);
      t = (x * (27 * (longint'(1) <<< 28) + s)) / (27 * (longint'(1) <<< 28) + 9 * s);
    end
    t = t >>> 12;
    p = longint'(a) * longint'(t);
    return longint'(p >> 16);
  endfunction

  function automatic longint sine_of(longint v);
    longint per, r, x, y, z, ang, dx, dy;
    per = (longint'(TWO_PI_Q32) + 32768) >>> 16;
    r = v % per;
    if (r < 0) r += per;
    z = r <<< 14;
    x = longint'(CORDIC_GAIN);
    y = 0;
    if (z > longint'(PI_Q30)) z -= longint'(TWO_PI_Q30);
    if (z > longint'(HALF_PI_Q30)) z = longint'(PI_Q30) - z;
    else if (z < -longint'(HALF_PI_Q30)) z = -longint'(PI_Q30) - z;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      ang = i < 10 ? ATAN_TAB[i] : (longint'(1) <<< (30 - i));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ang;
      end else begin
        x += dx; y -= dy; z += ang;
      end
    end
    return y >>> 14;
  endfunction

  function automatic plant_word_t advance_plant(ctl_word_t w);
    plant_word_t r;
    longint u, y, hi, lo;
    u = longint'(signed'(w.u));
    if (w.rs) begin
      y_hist1 = iy_last;
      y_hist2 = iy_older;
      u_hist = iu_last;
    end
    if (nonlinear) begin
      y = coef_mul(k_a, y_hist1) - coef_mul(k_b, damp_term(y_hist2))
          + coef_mul(k_c, u) + coef_mul(k_d, sine_of(u_hist));
      hi = CLAMP_Q16;
      lo = -CLAMP_Q16;
    end else begin
      y = coef_mul(k_a, y_hist1) + coef_mul(k_b, u);
      hi = SMAX;
      lo = SMIN;
    end
    r.lim = 0;
    if (y > hi) begin y = hi; r.lim = 1; end
    if (y < lo) begin y = lo; r.lim = 1; end
    u_hist = u;
    y_hist2 = y_hist1;
    y_hist1 = y;
    r.y = y[SW-1:0];
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [SW-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COEF_A:       k_a = longint'(signed'(val[23:0]));
      REG_COEF_B:       k_b = longint'(signed'(val[23:0]));
      REG_COEF_C:       k_c = longint'(signed'(val[23:0]));
      REG_COEF_D:       k_d = longint'(signed'(val[23:0]));
      REG_MODE:         nonlinear = val[0];
      REG_INIT_Y_OLDER: iy_older = longint'(signed'(val));
      REG_INIT_Y_LAST:  iy_last = longint'(signed'(val));
      default:          iu_last = longint'(signed'(val));
    endcase
  endtask

  task automatic setup(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c,
                       logic [SW-1:0] d, logic m, logic [SW-1:0] yo,
                       logic [SW-1:0] yl, logic [SW-1:0] ul);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
    write_reg(REG_MODE, {$urandom} << 1 | m);
    write_reg(REG_INIT_Y_OLDER, yo);
    write_reg(REG_INIT_Y_LAST, yl);
    write_reg(REG_INIT_U_LAST, ul);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (ctl_queue.size() != 0 || in_valid || plant_expected.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h007f_ffff : 32'hff80_0000;
      1, 2: return SW'($signed($urandom_range(131072)) - 65536);
      3: return SW'($signed($urandom_range(16384)) - 8192);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(6))
      0: return $urandom_range(3) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom;
      2: return SW'($signed($urandom_range(400000)) - 200000);
      3: return SW'($signed($urandom_range(1 << 20)) - (1 << 19));
      4: return SW'($signed($urandom_range(131072000)) - 65536000);
      default: return SW'($signed($urandom_range(2 << 16)) - (1 << 16) + (3 << 16)
                          * ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  task automatic push(logic [SW-1:0] u, logic rs);
    ctl_word_t w;
    w.u = u;
    w.rs = rs;
    ctl_queue.push_back(w);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    k_a = 0; k_b = 0; k_c = 0; k_d = 0; nonlinear = 0;
    iy_older = 0; iy_last = 0; iu_last = 0;
    y_hist1 = 0; y_hist2 = 0; u_hist = 0;
    no_idle = 0; hold_req = 0;
    errors = 0; n_lin = 0; n_nl = 0; n_lim = 0; n_restart = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // linear: unity gains, extremes and saturation
    setup(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
    push(32'h7fff_ffff, 0); push(32'h7fff_ffff, 0); push(32'h8000_0000, 1);
    push(32'h8000_0000, 0); push(0, 1); push(32'hffff_ffff, 0); push(1, 0);
    drain();
    setup(32'h007f_ffff, 32'hff80_0000, 32'h007f_ffff, 32'hff80_0000, 0,
          32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push(32'h7fff_ffff, 1); push(32'h8000_0000, 0); push(32'h0000_1234, 0);
    drain();
    // nonlinear: tanh knee, sine fold points, clamp in both directions
    setup(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1,
          32'h0003_0000, 32'h0002_ffff, 32'h0001_921f);
    push(32'h0000_0000, 1); push(32'h0003_243f, 0); push(32'hfffc_dbc1, 0);
    push(32'h0006_487f, 0); push(32'hfffe_6de1, 0); push(32'h7fff_ffff, 0);
    push(32'h8000_0000, 0); push(32'h03e8_0000, 1); push(32'hfc18_0000, 0);
    drain();
    setup(32'h007f_ffff, 32'hff80_0000, 32'hff80_0000, 32'h007f_ffff, 1,
          32'hfffd_0000, 32'h8000_0000, 32'h7fff_ffff);
    push(32'h7fff_ffff, 1); push(32'h0001_0000, 0); push(32'hffff_0000, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      logic m;
      m = (ph % 3) != 2;
      setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), m,
            rand_sample(), rand_sample(), rand_sample());
      no_idle = (ph == 4);
      if (ph == 6) hold_req = 1;
      for (int i = 0; i < 150; i++)
        push(rand_sample(), $urandom_range(19) == 0);
      drain();
      hold_req = 0;
      no_idle = 0;
    end
    repeat (400) @(posedge clk);
    $display("Covered %0d linear and %0d nonlinear steps, %0d limited, %0d restarts.",
             n_lin, n_nl, n_lim, n_restart);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      control_in <= '0;
      restart <= 0;
    end else begin
      if (in_valid && in_ready) begin
        ctl_word_t w;
        w.u = control_in;
        w.rs = restart;
        if (nonlinear) n_nl++; else n_lin++;
        if (restart) n_restart++;
        plant_expected.push_back(advance_plant(w));
      end
      if (!in_valid || in_ready) begin
        if (ctl_queue.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
          ctl_word_t w;
          w = ctl_queue.pop_front();
          in_valid <= 1;
          control_in <= w.u;
          restart <= w.rs;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        plant_word_t e;
        if (plant_expected.size() == 0) begin
          $display("%0t: unexpected word y=%h lim=%b", $time, plant_out, was_limited);
          errors++;
        end else begin
          e = plant_expected.pop_front();
          if (plant_out !== e.y) begin
            $display("%0t: plant_out expected %h actual %h", $time, e.y, plant_out);
            errors++;
          end
          if (was_limited !== e.lim) begin
            $display("%0t: was_limited expected %b actual %b", $time, e.lim, was_limited);
            errors++;
          end
          if (e.lim) n_lim++;
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left <= 3000;
        out_ready <= 0;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        out_ready <= 0;
      end else begin
        if (hold_left == 1) hold_left <= -1;
        out_ready <= no_idle || $urandom_range(99) >= 23;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end
endmodule

@@ files.f @@
rtl/sopm_pkg.sv
rtl/sopm_muldiv.sv
rtl/sopm_cordic.sv
rtl/second_order_plant_model_step.sv
dv/tb_top.sv
